@@ src/smfc_pkg.sv @@
`timescale 1ns / 1ps
package smfc_pkg;

  localparam int unsigned DivWidth    = 12;
  localparam int unsigned SelectLines = 4;
  localparam int unsigned ByteWidth   = 8;
  localparam int unsigned LastBit     = 7;

  // input actions
  typedef enum logic [1:0] {
    ACT_IDLE = 2'd0,
    ACT_PUSH = 2'd1,
    ACT_POP  = 2'd2,
    ACT_RSVD = 2'd3
  } smfc_action_t;

  // select modes
  localparam logic [1:0] SEL_AUTO  = 2'd0;
  localparam logic [1:0] SEL_AUTO1 = 2'd1;
  localparam logic [1:0] SEL_HOLD  = 2'd2;
  localparam logic [1:0] SEL_OFF   = 2'd3;

  // register indexes
  localparam logic [2:0] REG_DIVIDER = 3'd0;
  localparam logic [2:0] REG_POL     = 3'd1;
  localparam logic [2:0] REG_MODE    = 3'd2;
  localparam logic [2:0] REG_ID      = 3'd3;
  localparam logic [2:0] REG_TXMARK  = 3'd4;
  localparam logic [2:0] REG_RXMARK  = 3'd5;
  localparam logic [2:0] REG_IRQEN   = 3'd6;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] tx_byte;
    logic       miso;
  } smfc_in_t;

  typedef struct packed {
    logic       sck;
    logic       mosi;
    logic [3:0] select_n;
    logic [7:0] rx_byte;
    logic       rx_empty;
    logic       tx_full;
    logic       tx_pending;
    logic       rx_pending;
    logic       irq;
    logic       busy_res;
  } smfc_out_t;

  typedef struct packed {
    logic [DivWidth-1:0] clock_divider;
    logic                clock_polarity;
    logic [1:0]          select_mode;
    logic [1:0]          select_id;
    logic [3:0]          tx_mark;
    logic [2:0]          rx_mark;
    logic [1:0]          irq_enable;
    logic                release_hold;
  } smfc_cfg_t;

endpackage

@@ src/smfc_ram.sv @@
`timescale 1ns / 1ps
module smfc_ram #(
  parameter int unsigned DEPTH = 8,
  parameter int unsigned WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // registered read, held between reads
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ src/smfc_core.sv @@
`timescale 1ns / 1ps
module smfc_core #(
  parameter int unsigned FIFO_DEPTH = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  smfc_pkg::smfc_cfg_t cfg,
  input  logic              in_valid,
  output logic              in_ready,
  input  smfc_pkg::smfc_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output smfc_pkg::smfc_out_t out_data
);
  import smfc_pkg::*;

  localparam int unsigned PW = $clog2(FIFO_DEPTH);
  localparam int unsigned CW = $clog2(FIFO_DEPTH + 1);
  localparam int unsigned MW = (CW > 4) ? CW : 4;

  function automatic logic [PW-1:0] adv(input logic [PW-1:0] p);
    adv = (p == PW'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // state
  logic [PW-1:0] tx_rp_r, tx_rp_nxt, tx_wp_r, tx_wp_nxt;
  logic [PW-1:0] rx_rp_r, rx_rp_nxt, rx_wp_r, rx_wp_nxt;
  logic [CW-1:0] tx_cnt_r, tx_cnt_nxt, rx_cnt_r, rx_cnt_nxt;
  logic [7:0]    shift_out_r, shift_out_nxt, shift_in_r, shift_in_nxt;
  logic [2:0]    bit_idx_r, bit_idx_nxt;
  logic [DivWidth-1:0] hp_cnt_r, hp_cnt_nxt;
  logic          phase_r, phase_nxt, active_r, active_nxt, held_r, held_nxt;
  logic          load_pend_r, load_pend_nxt, fwd_r, fwd_nxt;
  logic [7:0]    fwd_byte_r, fwd_byte_nxt;

  // first stage: flags waiting on memory read data
  logic          s1_valid_r;
  logic          s1_pop_ok_r, s1_mosi_mem_r;
  smfc_out_t     s1_data_r, s1_data_nxt;
  logic          pop_ok, mosi_mem;

  // output stage
  logic          out_valid_r;
  smfc_out_t     out_data_r;

  logic          acc, s1_move;
  logic          tx_wr_en, tx_rd_en, rx_wr_en, rx_rd_en;
  logic [7:0]    tx_rdata, rx_rdata, shift_eff, mem_word;
  logic          asserted;
  smfc_out_t     s1_res;

  assign s1_move  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_move;
  assign acc      = in_valid && in_ready;

  smfc_ram #(.DEPTH(FIFO_DEPTH), .WIDTH(ByteWidth)) u_tx_ram (
    .clk    (clk),
    .wr_en  (tx_wr_en),
    .wr_addr(tx_wp_r),
    .wr_data(in_data.tx_byte),
    .rd_en  (tx_rd_en),
    .rd_addr(tx_rp_r),
    .rd_data(tx_rdata)
  );

  smfc_ram #(.DEPTH(FIFO_DEPTH), .WIDTH(ByteWidth)) u_rx_ram (
    .clk    (clk),
    .wr_en  (rx_wr_en),
    .wr_addr(rx_wp_r),
    .wr_data(shift_in_r),
    .rd_en  (rx_rd_en),
    .rd_addr(rx_rp_r),
    .rd_data(rx_rdata)
  );

  assign mem_word  = fwd_r ? fwd_byte_r : tx_rdata;
  assign shift_eff = load_pend_r ? mem_word : shift_out_r;

  // advance fifos and shifter only on an accepted word
  always_comb begin
    logic start;
    start         = 1'b0;
    tx_rp_nxt     = tx_rp_r;
    tx_wp_nxt     = tx_wp_r;
    tx_cnt_nxt    = tx_cnt_r;
    rx_rp_nxt     = rx_rp_r;
    rx_wp_nxt     = rx_wp_r;
    rx_cnt_nxt    = rx_cnt_r;
    shift_out_nxt = shift_out_r;
    shift_in_nxt  = shift_in_r;
    bit_idx_nxt   = bit_idx_r;
    hp_cnt_nxt    = hp_cnt_r;
    phase_nxt     = phase_r;
    active_nxt    = active_r;
    held_nxt      = cfg.release_hold ? 1'b0 : held_r;
    load_pend_nxt = load_pend_r;
    fwd_nxt       = fwd_r;
    fwd_byte_nxt  = fwd_byte_r;
    tx_wr_en      = 1'b0;
    tx_rd_en      = 1'b0;
    rx_wr_en      = 1'b0;
    rx_rd_en      = 1'b0;
    pop_ok        = 1'b0;
    mosi_mem      = 1'b0;
    s1_data_nxt   = '0;

    if (acc) begin
      shift_out_nxt = shift_eff;
      load_pend_nxt = 1'b0;
      // push or pop
      if (in_data.action == ACT_PUSH) begin
        if (tx_cnt_r != CW'(FIFO_DEPTH)) begin
          tx_wr_en   = 1'b1;
          tx_wp_nxt  = adv(tx_wp_r);
          tx_cnt_nxt = tx_cnt_r + 1'b1;
        end
      end else if (in_data.action == ACT_POP) begin
        if (rx_cnt_r != '0) begin
          rx_rd_en   = 1'b1;
          pop_ok     = 1'b1;
          rx_rp_nxt  = adv(rx_rp_r);
          rx_cnt_nxt = rx_cnt_r - 1'b1;
        end else begin
          s1_data_nxt.rx_empty = 1'b1;
        end
      end

      // shifter
      if (!active_r) begin
        start = (tx_cnt_nxt != '0);
      end else if (hp_cnt_r < cfg.clock_divider) begin
        hp_cnt_nxt = hp_cnt_r + 1'b1;
      end else begin
        hp_cnt_nxt = '0;
        if (!phase_r) begin
          shift_in_nxt = {shift_in_r[6:0], in_data.miso};
          phase_nxt    = 1'b1;
        end else begin
          phase_nxt     = 1'b0;
          shift_out_nxt = {shift_eff[6:0], 1'b0};
          if (bit_idx_r != 3'(LastBit)) begin
            bit_idx_nxt = bit_idx_r + 1'b1;
          end else begin
            if (rx_cnt_nxt != CW'(FIFO_DEPTH)) begin
              rx_wr_en   = 1'b1;
              rx_wp_nxt  = adv(rx_wp_r);
              rx_cnt_nxt = rx_cnt_nxt + 1'b1;
            end
            if (tx_cnt_nxt != '0) begin
              start = 1'b1;
            end else begin
              active_nxt  = 1'b0;
              bit_idx_nxt = '0;
            end
          end
        end
      end

      // load next byte; forward a push into an empty fifo
      if (start) begin
        tx_rd_en      = 1'b1;
        fwd_nxt       = tx_wr_en && (tx_wp_r == tx_rp_r);
        fwd_byte_nxt  = in_data.tx_byte;
        tx_rp_nxt     = adv(tx_rp_r);
        tx_cnt_nxt    = tx_cnt_nxt - 1'b1;
        shift_in_nxt  = '0;
        bit_idx_nxt   = '0;
        hp_cnt_nxt    = '0;
        phase_nxt     = 1'b0;
        active_nxt    = 1'b1;
        load_pend_nxt = 1'b1;
        mosi_mem      = 1'b1;
        if (cfg.select_mode == SEL_HOLD) begin
          held_nxt = 1'b1;
        end
      end

      // result fields known this cycle
      s1_data_nxt.sck  = active_nxt ? (phase_nxt ? cfg.clock_polarity : ~cfg.clock_polarity)
                                    : cfg.clock_polarity;
      s1_data_nxt.mosi = active_nxt && shift_out_nxt[7];
      asserted = (cfg.select_mode != SEL_OFF) &&
                 (active_nxt || (cfg.select_mode == SEL_HOLD && held_nxt));
      s1_data_nxt.select_n   = asserted ? ~(4'b0001 << cfg.select_id) : 4'hf;
      s1_data_nxt.tx_full    = (tx_cnt_nxt == CW'(FIFO_DEPTH));
      s1_data_nxt.tx_pending = MW'(tx_cnt_nxt) < MW'(cfg.tx_mark);
      s1_data_nxt.rx_pending = MW'(rx_cnt_nxt) > MW'(cfg.rx_mark);
      s1_data_nxt.irq        = (cfg.irq_enable[0] && s1_data_nxt.tx_pending) ||
                               (cfg.irq_enable[1] && s1_data_nxt.rx_pending);
      s1_data_nxt.busy_res   = active_nxt;
    end else begin
      asserted = 1'b0;
    end
  end

  // merge memory read data into the result
  always_comb begin
    s1_res         = s1_data_r;
    s1_res.rx_byte = s1_pop_ok_r ? rx_rdata : '0;
    if (s1_mosi_mem_r) begin
      s1_res.mosi = mem_word[7];
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tx_rp_r     <= '0;
      tx_wp_r     <= '0;
      tx_cnt_r    <= '0;
      rx_rp_r     <= '0;
      rx_wp_r     <= '0;
      rx_cnt_r    <= '0;
      shift_out_r <= '0;
      shift_in_r  <= '0;
      bit_idx_r   <= '0;
      hp_cnt_r    <= '0;
      phase_r     <= 1'b0;
      active_r    <= 1'b0;
      held_r      <= 1'b0;
      load_pend_r <= 1'b0;
      fwd_r       <= 1'b0;
    end else begin
      tx_rp_r     <= tx_rp_nxt;
      tx_wp_r     <= tx_wp_nxt;
      tx_cnt_r    <= tx_cnt_nxt;
      rx_rp_r     <= rx_rp_nxt;
      rx_wp_r     <= rx_wp_nxt;
      rx_cnt_r    <= rx_cnt_nxt;
      shift_out_r <= shift_out_nxt;
      shift_in_r  <= shift_in_nxt;
      bit_idx_r   <= bit_idx_nxt;
      hp_cnt_r    <= hp_cnt_nxt;
      phase_r     <= phase_nxt;
      active_r    <= active_nxt;
      held_r      <= held_nxt;
      load_pend_r <= load_pend_nxt;
      fwd_r       <= fwd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fwd_byte_r <= fwd_byte_nxt;
  end

  // pipeline stage and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (acc) begin
        s1_valid_r <= 1'b1;
      end else if (s1_move) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_move) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_data_r     <= s1_data_nxt;
      s1_pop_ok_r   <= pop_ok;
      s1_mosi_mem_r <= mosi_mem;
    end
    if (s1_move) begin
      out_data_r <= s1_res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ src/spi_master_fifo_controller.sv @@
`timescale 1ns / 1ps
// Two register stages; an accepted input word is registered in the first
// stage and moves to the output register once that is empty or being taken.
// Throughput: one word per cycle while out_ready holds; the fifo memories
// have a registered read, and a pipeline stage plus output register absorb it.
// Reset (rst_n, synchronous, active low) empties both fifos, idles the
// shifter, releases the held select and restores register defaults.
module spi_master_fifo_controller #(
  parameter int unsigned FIFO_DEPTH = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  smfc_pkg::smfc_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output smfc_pkg::smfc_out_t out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import smfc_pkg::*;

  logic [DivWidth-1:0] div_r;
  logic                pol_r;
  logic [1:0]          mode_r, id_r, irqen_r;
  logic [3:0]          txmark_r;
  logic [2:0]          rxmark_r;
  logic                wr, release_hold;
  logic [2:0]          idx;
  smfc_cfg_t           cfg;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = paddr[4:2];

  // drop a held select when mode or id changes in hold mode
  always_comb begin
    release_hold = 1'b0;
    if (wr && mode_r == SEL_HOLD) begin
      if (idx == REG_MODE && pwdata[1:0] != SEL_HOLD) begin
        release_hold = 1'b1;
      end
      if (idx == REG_ID && pwdata[1:0] != id_r) begin
        release_hold = 1'b1;
      end
    end
  end

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_r    <= DivWidth'(3);
      pol_r    <= 1'b0;
      mode_r   <= SEL_AUTO;
      id_r     <= '0;
      txmark_r <= '0;
      rxmark_r <= '0;
      irqen_r  <= '0;
    end else if (wr) begin
      case (idx)
        REG_DIVIDER: div_r    <= pwdata[DivWidth-1:0];
        REG_POL:     pol_r    <= pwdata[0];
        REG_MODE:    mode_r   <= pwdata[1:0];
        REG_ID:      id_r     <= pwdata[1:0];
        REG_TXMARK:  txmark_r <= pwdata[3:0];
        REG_RXMARK:  rxmark_r <= pwdata[2:0];
        REG_IRQEN:   irqen_r  <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  // register reads
  always_comb begin
    case (idx)
      REG_DIVIDER: prdata = 32'(div_r);
      REG_POL:     prdata = 32'(pol_r);
      REG_MODE:    prdata = 32'(mode_r);
      REG_ID:      prdata = 32'(id_r);
      REG_TXMARK:  prdata = 32'(txmark_r);
      REG_RXMARK:  prdata = 32'(rxmark_r);
      REG_IRQEN:   prdata = 32'(irqen_r);
      default:     prdata = '0;
    endcase
  end

  always_comb begin
    cfg.clock_divider  = div_r;
    cfg.clock_polarity = pol_r;
    cfg.select_mode    = mode_r;
    cfg.select_id      = id_r;
    cfg.tx_mark        = txmark_r;
    cfg.rx_mark        = rxmark_r;
    cfg.irq_enable     = irqen_r;
    cfg.release_hold   = release_hold;
  end

  smfc_core #(.FIFO_DEPTH(FIFO_DEPTH)) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

endmodule

@@ src/smfc_checker.sv @@
`timescale 1ns / 1ps
module smfc_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_ready,
  input smfc_pkg::smfc_out_t out_data
);

  // hold a stalled result word
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result word changed");

  // no result right after reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // empty pop returns zero
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.rx_empty |-> out_data.rx_byte == 8'd0)
    else $error("empty pop returned data");

  // idle shifter drives mosi low
  a_idle_mosi: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.busy_res |-> !out_data.mosi)
    else $error("mosi high while idle");

endmodule

bind spi_master_fifo_controller smfc_checker u_smfc_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data (out_data)
);
